// File: rtl/nibble_weight_dequantizer_core_macros.svh
// ----------------------------------------------------------------------------
// Nibble weight dequantizer assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_WEIGHT_DEQUANTIZER_CORE_MACROS_SVH
`define NIBBLE_WEIGHT_DEQUANTIZER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define NWD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nwd assertion failed");
`define NWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nwd assertion failed");
`else
`define NWD_ASSERT_IMP(label, ante, cons)
`define NWD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/nwd_pkg.sv
// ----------------------------------------------------------------------------
// Nibble weight dequantizer package
// Beat types, codebooks and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none
package nwd_pkg;

    localparam int LANES  = 8;
    localparam int CODE_W = 4;

    typedef enum logic [1:0] {
        FMT_FP4  = 2'd0,
        FMT_INT4 = 2'd1,
        FMT_NF4  = 2'd2
    } nwd_fmt_t;

    typedef enum logic [1:0] {
        CLS_NORM = 2'd0,
        CLS_ZERO = 2'd1,
        CLS_INF  = 2'd2,
        CLS_NAN  = 2'd3
    } nwd_class_t;

    typedef struct packed {
        logic [31:0] packed_word;
        logic [31:0] scale_bits;
    } nwd_in_t;

    typedef struct packed {
        logic [31:0] weight_0;
        logic [31:0] weight_1;
        logic [31:0] weight_2;
        logic [31:0] weight_3;
        logic [31:0] weight_4;
        logic [31:0] weight_5;
        logic [31:0] weight_6;
        logic [31:0] weight_7;
    } nwd_out_t;

    typedef struct packed {
        logic              sign;
        nwd_class_t        cls;
        logic signed [9:0] exp;
        logic [23:0]       mant;
    } nwd_scale_t;

    localparam logic [31:0] QNAN    = 32'h7FC0_0000;
    localparam logic [31:0] INF_MAG = 32'h7F80_0000;

    localparam logic [31:0] FP4_TABLE [16] = '{
        32'h0000_0000, 32'h3F00_0000, 32'h3F80_0000, 32'h3FC0_0000,
        32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 32'h40C0_0000,
        32'h8000_0000, 32'hBF00_0000, 32'hBF80_0000, 32'hBFC0_0000,
        32'hC000_0000, 32'hC040_0000, 32'hC080_0000, 32'hC0C0_0000
    };

    localparam logic [31:0] INT4_TABLE [16] = '{
        32'hC100_0000, 32'hC0E0_0000, 32'hC0C0_0000, 32'hC0A0_0000,
        32'hC080_0000, 32'hC040_0000, 32'hC000_0000, 32'hBF80_0000,
        32'h0000_0000, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000,
        32'h4080_0000, 32'h40A0_0000, 32'h40C0_0000, 32'h40E0_0000
    };

    localparam logic [31:0] NF4_TABLE [16] = '{
        32'hBF80_0000, 32'hBF32_39B1, 32'hBF06_6B30, 32'hBECA_32A0,
        32'hBE91_A24D, 32'hBE3D_353F, 32'hBDBA_7871, 32'h0000_0000,
        32'h3DA2_FAFF, 32'h3E24_CAE3, 32'h3E7C_04DD, 32'h3EAD_033A,
        32'h3EE1_A4B8, 32'h3F10_07AB, 32'h3F39_13B3, 32'h3F80_0000
    };

    function automatic logic [31:0] decode_code(logic [1:0] fmt, logic [CODE_W-1:0] code);
        logic [31:0] bits;
        if (fmt == FMT_FP4)
            bits = FP4_TABLE[code];
        else if (fmt == FMT_INT4)
            bits = INT4_TABLE[code];
        else
            bits = NF4_TABLE[code];
        return bits;
    endfunction

endpackage
`default_nettype wire

// File: rtl/nibble_weight_dequantizer_core.sv
// ----------------------------------------------------------------------------
// Nibble weight dequantizer core
// Eight 4-bit codes and a binary32 scale in, eight binary32 weights out.
// ----------------------------------------------------------------------------
// One beat is taken every cycle and busy stays low; each result appears on
// result with a one-cycle result_strobe, registered in turn by the input
// register, the decode and scale stage, the 24x24 multiplier stage in each
// of the eight lanes and the merge register.
// The receiver cannot stall, so results must be taken as they come.
`default_nettype none
`include "nibble_weight_dequantizer_core_macros.svh"
module nibble_weight_dequantizer_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire nwd_pkg::nwd_in_t   item,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_wdata,
    output nwd_pkg::nwd_out_t       result,
    output logic                    result_strobe
);
    import nwd_pkg::*;

    logic [1:0] format_reg;
    nwd_in_t    in_reg;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    nwd_scale_t scale;
    logic [31:0] lane_weight [LANES];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_FP4;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                format_reg <= cfg_wdata;
            v1_reg <= start & ~busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
            in_reg <= item;
    end

    nwd_scale_prep u_scale_prep (
        .clk        (clk),
        .scale_bits (in_reg.scale_bits),
        .scale      (scale)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        nwd_lane u_lane (
            .clk    (clk),
            .fmt    (format_reg),
            .code   (in_reg.packed_word[CODE_W*g +: CODE_W]),
            .scale  (scale),
            .weight (lane_weight[g])
        );
    end

    nwd_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .lane_valid    (v3_reg),
        .lane_weight   (lane_weight),
        .result        (result),
        .result_strobe (result_strobe)
    );

    `NWD_ASSERT_IMP(a_latency, start && !busy, ##4 result_strobe)
    `NWD_ASSERT_IMP(a_no_orphan, result_strobe, $past(start && !busy, 4))
    `NWD_ASSERT_NEXT(a_stage_follow, v2_reg, v3_reg)

endmodule
`default_nettype wire

// File: rtl/nwd_scale_prep.sv
// ----------------------------------------------------------------------------
// Nibble weight dequantizer scale preparation
// Classifies the scale and normalises a subnormal mantissa.
// ----------------------------------------------------------------------------
`default_nettype none
module nwd_scale_prep (
    input  wire logic               clk,
    input  wire logic [31:0]        scale_bits,
    output nwd_pkg::nwd_scale_t     scale
);
    import nwd_pkg::*;

    nwd_scale_t  scale_reg;
    nwd_scale_t  scale_next;
    logic [7:0]  exp_f;
    logic [22:0] man_f;
    logic [4:0]  lead;
    logic [4:0]  shl;

    always_comb
    begin
        exp_f = scale_bits[30:23];
        man_f = scale_bits[22:0];
        lead  = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (man_f[i])
                lead = 5'(i);
        end
        shl = 5'd23 - lead;
        scale_next.sign = scale_bits[31];
        if (exp_f == 8'hFF)
            scale_next.cls = (man_f != 23'd0) ? CLS_NAN : CLS_INF;
        else if (exp_f == 8'd0 && man_f == 23'd0)
            scale_next.cls = CLS_ZERO;
        else
            scale_next.cls = CLS_NORM;
        if (exp_f == 8'd0)
        begin
            scale_next.mant = {1'b0, man_f} << shl;
            scale_next.exp  = 10'sd1 - signed'({5'd0, shl});
        end
        else
        begin
            scale_next.mant = {1'b1, man_f};
            scale_next.exp  = signed'({2'd0, exp_f});
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
    end

    assign scale = scale_reg;

endmodule
`default_nettype wire

// File: rtl/nwd_lane.sv
// ----------------------------------------------------------------------------
// Nibble weight dequantizer lane
// Decodes one code, multiplies by the scale and rounds to binary32.
// ----------------------------------------------------------------------------
`default_nettype none
module nwd_lane (
    input  wire logic                        clk,
    input  wire logic [1:0]                  fmt,
    input  wire logic [nwd_pkg::CODE_W-1:0]  code,
    input  wire nwd_pkg::nwd_scale_t         scale,
    output logic [31:0]                      weight
);
    import nwd_pkg::*;

    logic [31:0]        a_reg;
    logic [47:0]        prod_reg;
    logic [47:0]        prod_next;
    logic signed [10:0] exp_reg;
    logic signed [10:0] exp_next;
    logic               sign_reg;
    logic               sign_next;
    nwd_class_t         kind_reg;
    nwd_class_t         kind_next;
    logic               a_zero;

    logic signed [11:0] e1;
    logic signed [11:0] extra;
    logic signed [11:0] ef;
    logic [6:0]         base;
    logic [6:0]         sh7;
    logic [5:0]         sh;
    logic [96:0]        wide;
    logic [24:0]        q;
    logic               rnd;
    logic [25:0]        qr;
    logic [31:0]        norm_bits;

    always_ff @(posedge clk)
    begin
        a_reg <= decode_code(fmt, code);
    end

    always_comb
    begin
        a_zero    = (a_reg[30:23] == 8'd0);
        sign_next = a_reg[31] ^ scale.sign;
        prod_next = {1'b1, a_reg[22:0]} * scale.mant;
        exp_next  = signed'({3'd0, a_reg[30:23]}) + {scale.exp[9], scale.exp} - 11'sd127;
        unique case (scale.cls)
            CLS_NAN:  kind_next = CLS_NAN;
            CLS_INF:  kind_next = a_zero ? CLS_NAN : CLS_INF;
            CLS_ZERO: kind_next = CLS_ZERO;
            default:  kind_next = a_zero ? CLS_ZERO : CLS_NORM;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        exp_reg  <= exp_next;
        sign_reg <= sign_next;
        kind_reg <= kind_next;
    end

    always_comb
    begin
        e1    = {exp_reg[10], exp_reg} + (prod_reg[47] ? 12'sd1 : 12'sd0);
        base  = prod_reg[47] ? 7'd24 : 7'd23;
        extra = 12'sd1 - e1;
        if (e1 < 12'sd1)
            sh7 = base + ((extra > 12'sd40) ? 7'd40 : extra[6:0]);
        else
            sh7 = base;
        sh   = (sh7 > 7'd49) ? 6'd49 : sh7[5:0];
        wide = {prod_reg, 49'd0} >> sh;
        q    = wide[73:49];
        rnd  = wide[48] & ((|wide[47:0]) | q[0]);
        qr   = {1'b0, q} + {25'd0, rnd};
        ef   = e1;
        if (e1 >= 12'sd255)
            norm_bits = {sign_reg, INF_MAG[30:0]};
        else if (e1 < 12'sd1)
            norm_bits = {sign_reg, 31'd0} | {8'd0, qr[23:0]};
        else
        begin
            if (qr == 26'h100_0000)
                ef = e1 + 12'sd1;
            if (ef >= 12'sd255)
                norm_bits = {sign_reg, INF_MAG[30:0]};
            else
                norm_bits = {sign_reg, ef[7:0], qr[22:0]};
        end
        unique case (kind_reg)
            CLS_NAN:  weight = QNAN;
            CLS_INF:  weight = {sign_reg, INF_MAG[30:0]};
            CLS_ZERO: weight = {sign_reg, 31'd0};
            default:  weight = norm_bits;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/nwd_merge.sv
// ----------------------------------------------------------------------------
// Nibble weight dequantizer merge stage
// Gathers the lane weights into one result beat and raises the strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module nwd_merge (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                lane_valid,
    input  wire logic [31:0]         lane_weight [nwd_pkg::LANES],
    output nwd_pkg::nwd_out_t        result,
    output logic                     result_strobe
);
    import nwd_pkg::*;

    nwd_out_t result_reg;
    nwd_out_t result_next;
    logic     strobe_reg;

    always_comb
    begin
        result_next.weight_0 = lane_weight[0];
        result_next.weight_1 = lane_weight[1];
        result_next.weight_2 = lane_weight[2];
        result_next.weight_3 = lane_weight[3];
        result_next.weight_4 = lane_weight[4];
        result_next.weight_5 = lane_weight[5];
        result_next.weight_6 = lane_weight[6];
        result_next.weight_7 = lane_weight[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= lane_valid;
    end

    always_ff @(posedge clk)
    begin
        if (lane_valid)
            result_reg <= result_next;
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule
`default_nettype wire

// File: verif/tb_nibble_weight_dequantizer_core.sv
// ----------------------------------------------------------------------------
// Nibble weight dequantizer testbench
// Drives word and scale beats through every code format, predicts the eight
// binary32 products with a bit-exact multiplier and checks each result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_nibble_weight_dequantizer_core;
    import nwd_pkg::*;

    localparam int  CYCLE_LIMIT = 200000;
    localparam int  LATENCY     = 4;
    localparam int  RAND_BEATS  = 750;
    localparam logic [1:0] FMT_SPARE = 2'd3;

    // Codebooks in this testbench's own terms.
    localparam logic [31:0] FP4_LVL [16] = '{
        32'h0000_0000, 32'h3F00_0000, 32'h3F80_0000, 32'h3FC0_0000,
        32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 32'h40C0_0000,
        32'h8000_0000, 32'hBF00_0000, 32'hBF80_0000, 32'hBFC0_0000,
        32'hC000_0000, 32'hC040_0000, 32'hC080_0000, 32'hC0C0_0000
    };
    localparam logic [31:0] NF4_LVL [16] = '{
        32'hBF80_0000, 32'hBF32_39B1, 32'hBF06_6B30, 32'hBECA_32A0,
        32'hBE91_A24D, 32'hBE3D_353F, 32'hBDBA_7871, 32'h0000_0000,
        32'h3DA2_FAFF, 32'h3E24_CAE3, 32'h3E7C_04DD, 32'h3EAD_033A,
        32'h3EE1_A4B8, 32'h3F10_07AB, 32'h3F39_13B3, 32'h3F80_0000
    };
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    class weight_scoreboard;
        logic [1:0] fmt;
        nwd_out_t   pending_weights[$];
        int         errors;

        function new();
            fmt = FMT_FP4;
            errors = 0;
        endfunction

        function logic [31:0] level_of(logic [3:0] code);
            logic [31:0] v;
            int          m;
            int          e;
            if (fmt == FMT_FP4)
                return FP4_LVL[code];
            if (fmt != FMT_INT4)
                return NF4_LVL[code];
            m = int'(code) - 8;
            if (m == 0)
                return 32'h0;
            v = (m < 0) ? 32'h8000_0000 : 32'h0;
            if (m < 0)
                m = -m;
            e = 0;
            while ((m >> (e + 1)) != 0)
                e++;
            return v | ((e + 127) << 23) | ((m << (23 - e)) & 32'h7F_FFFF);
        endfunction

        function logic [31:0] fp32_product(logic [31:0] a, logic [31:0] b);
            logic [31:0] sgn;
            int          ea;
            int          eb;
            int          e;
            int          shift;
            logic [23:0] ma;
            logic [23:0] mb;
            logic [63:0] p;
            logic [63:0] q;
            logic [63:0] rem;
            logic [63:0] half;
            bit          az;
            bit          bz;
            sgn = (a ^ b) & 32'h8000_0000;
            ea = a[30:23];
            eb = b[30:23];
            ma = {1'b0, a[22:0]};
            mb = {1'b0, b[22:0]};
            az = (ea == 0 && ma == 0);
            bz = (eb == 0 && mb == 0);
            if ((ea == 255 && ma != 0) || (eb == 255 && mb != 0))
                return CANON_NAN;
            if (ea == 255 || eb == 255)
                return (az || bz) ? CANON_NAN : (sgn | INF_BITS);
            if (az || bz)
                return sgn;
            if (ea == 0)
            begin
                ea = 1;
                while (!ma[23])
                begin
                    ma = ma << 1;
                    ea--;
                end
            end
            else
                ma[23] = 1'b1;
            if (eb == 0)
            begin
                eb = 1;
                while (!mb[23])
                begin
                    mb = mb << 1;
                    eb--;
                end
            end
            else
                mb[23] = 1'b1;
            p = 64'(ma) * 64'(mb);
            e = ea + eb - 127;
            if (p[47])
            begin
                shift = 24;
                e++;
            end
            else
                shift = 23;
            if (e >= 255)
                return sgn | INF_BITS;
            if (e < 1)
            begin
                shift += (1 - e > 40) ? 40 : 1 - e;
                e = 0;
            end
            if (shift > 62)
                q = 0;
            else
            begin
                q = p >> shift;
                rem = p & ((64'd1 << shift) - 1);
                half = 64'd1 << (shift - 1);
                if (rem > half || (rem == half && q[0]))
                    q++;
            end
            if (e == 0)
                return sgn | q[31:0];
            if (q == (64'd1 << 24))
            begin
                q = q >> 1;
                e++;
            end
            if (e >= 255)
                return sgn | INF_BITS;
            return sgn | (e << 23) | (q[31:0] & 32'h7F_FFFF);
        endfunction

        function void note_beat(nwd_in_t beat);
            logic [31:0] w [8];
            nwd_out_t    r;
            for (int j = 0; j < 8; j++)
                w[j] = fp32_product(level_of(beat.packed_word[4*j +: 4]), beat.scale_bits);
            r = '{w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
            pending_weights.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %h, got %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(nwd_out_t got);
            nwd_out_t want;
            if (pending_weights.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                errors++;
                return;
            end
            want = pending_weights.pop_front();
            compare("weight_0", want.weight_0, got.weight_0);
            compare("weight_1", want.weight_1, got.weight_1);
            compare("weight_2", want.weight_2, got.weight_2);
            compare("weight_3", want.weight_3, got.weight_3);
            compare("weight_4", want.weight_4, got.weight_4);
            compare("weight_5", want.weight_5, got.weight_5);
            compare("weight_6", want.weight_6, got.weight_6);
            compare("weight_7", want.weight_7, got.weight_7);
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    nwd_in_t  item;
    logic     cfg_we;
    logic [1:0] cfg_wdata;
    nwd_out_t result;
    logic     result_strobe;

    weight_scoreboard sb;
    int       cycles;
    int       beats_sent;
    int       results_seen;

    nibble_weight_dequantizer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result        (result),
        .result_strobe (result_strobe)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && start && !busy)
        begin
            sb.note_beat(item);
            beats_sent <= beats_sent + 1;
        end
        if (rst_n && result_strobe)
        begin
            sb.check_result(result);
            results_seen <= results_seen + 1;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] random_scale();
        logic [31:0] s;
        s = $urandom;
        case ($urandom_range(9))
            0: s[30:23] = 8'd0;
            1: s[30:23] = 8'hFF;
            2: s[30:23] = 8'($urandom_range(1, 12));
            3: s[30:23] = 8'($urandom_range(240, 254));
            4: s[30:0] = 31'd0;
            default: s[30:23] = 8'($urandom_range(100, 150));
        endcase
        return s;
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(3) == 0)
            n = 0;
        repeat (n) @(negedge clk);
    endtask

    // Hold the beat until it is taken, then drop start only if a gap follows.
    task automatic send_beat(logic [31:0] word, logic [31:0] scale, bit gap);
        start = 1'b1;
        item = '{word, scale};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (gap)
        begin
            start = 1'b0;
            idle_gap();
        end
    endtask

    task automatic drain();
        start = 1'b0;
        while (sb.pending_weights.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic set_format(logic [1:0] f);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = f;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.fmt = f;
    endtask

    task automatic directed_beats();
        send_beat(32'h7654_3210, 32'h3F80_0000, 0);
        send_beat(32'hFEDC_BA98, 32'h3F80_0000, 0);
        send_beat(32'h0000_0000, 32'h0000_0000, 1);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_beat(32'h8F08_F0F8, 32'h7F80_0000, 0);
        send_beat(32'h8F08_F0F8, 32'hFF80_0000, 1);
        send_beat(32'h7654_3210, 32'h7FC0_0001, 0);
        send_beat(32'hFEDC_BA98, 32'h7F7F_FFFF, 0);
        send_beat(32'h7654_3210, 32'h0000_0001, 1);
        send_beat(32'hFEDC_BA98, 32'h8080_0000, 0);
        send_beat(32'h1357_9BDF, 32'h0040_0001, 0);
        send_beat(32'hA5A5_5A5A, 32'h8000_0000, 1);
    endtask

    initial
    begin
        logic [1:0] fmt_plan [6];
        sb = new();
        cycles = 0;
        beats_sent = 0;
        results_seen = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = FMT_FP4;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset format first, then every setting including the unused code.
        directed_beats();
        fmt_plan = '{FMT_INT4, FMT_NF4, FMT_SPARE, FMT_FP4, FMT_NF4, FMT_INT4};
        foreach (fmt_plan[i])
        begin
            set_format(fmt_plan[i]);
            if (i < 4)
                directed_beats();
            for (int k = 0; k < RAND_BEATS / 6; k++)
            begin
                send_beat($urandom, random_scale(), $urandom_range(2) == 0);
                if (k == 60)
                    drain();
            end
        end
        drain();

        $display("%0d beats sent, %0d result beats checked over all code formats",
                 beats_sent, results_seen);
        $display("special scales covered: zero, subnormal, overflow, infinity, NaN");
        if (sb.errors == 0 && sb.pending_weights.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/nwd_pkg.sv
rtl/nwd_scale_prep.sv
rtl/nwd_lane.sv
rtl/nwd_merge.sv
rtl/nibble_weight_dequantizer_core.sv
verif/tb_nibble_weight_dequantizer_core.sv
